@@ design/breakpoint_match_table_assert.svh @@
// Assertion macros shared by the breakpoint match table checker.
`ifndef BREAKPOINT_MATCH_TABLE_ASSERT_SVH
`define BREAKPOINT_MATCH_TABLE_ASSERT_SVH

// Assertion that is checked only outside reset.
`define BMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define BMT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bmt_pkg.sv @@
// Package with the types and constants of the breakpoint match table.
`default_nettype none
package bmt_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_CHECK  = 2'd3;

  localparam logic signed [31:0] TAG_NONE = -32'sd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] method_id;
    logic [30:0] line_number;
    logic [30:0] request_tag;
    logic [15:0] call_depth;
    logic [15:0] step_target_depth;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               hit;
    logic signed [31:0] hit_tag;
    logic               step_cleared;
  } rsp_t;

  typedef struct packed {
    logic [63:0] method_id;
    logic [30:0] line_number;
    logic [30:0] request_tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    RES_PLAIN = 2'd0,
    RES_FULL  = 2'd1,
    RES_STEP  = 2'd2,
    RES_TAG   = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     clear_count;
    logic     scan_en;
    logic     read_last;
    logic     append;
    logic     move;
    logic     dec_count;
    logic     set_res;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       step_mode;
    logic       step_hit;
    logic       cmp_hit;
    logic       scan_end;
    logic       match_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/bmt_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module bmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/bmt_ctrl.sv @@
// Controller state machine of the breakpoint match table.
`default_nettype none
module bmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bmt_pkg::sts_t sts,
  output bmt_pkg::cmd_t      cmd
);
  import bmt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECODE    = 6'b000010,
    S_SCAN      = 6'b000100,
    S_READ_LAST = 6'b001000,
    S_MOVE      = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_sel = RES_PLAIN;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next  = S_FINISH;
        cmd.set_res = 1'b1;
        unique case (sts.kind)
          KIND_ADD: begin
            if (sts.full) begin
              cmd.res_sel = RES_FULL;
            end else if (sts.empty) begin
              cmd.append = 1'b1;
            end else begin
              cmd.set_res = 1'b0;
              state_next  = S_SCAN;
            end
          end
          KIND_REMOVE: begin
            if (!sts.empty) begin
              cmd.set_res = 1'b0;
              state_next  = S_SCAN;
            end
          end
          KIND_CLEAR: begin
            cmd.clear_count = 1'b1;
          end
          KIND_CHECK: begin
            if (sts.step_mode) begin
              cmd.res_sel = sts.step_hit ? RES_STEP : RES_PLAIN;
            end else if (!sts.empty) begin
              cmd.set_res = 1'b0;
              state_next  = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.cmp_hit) begin
          cmd.set_res = 1'b1;
          state_next  = S_FINISH;
          unique case (sts.kind)
            KIND_REMOVE: begin
              if (sts.match_last) begin
                cmd.dec_count = 1'b1;
              end else begin
                cmd.set_res = 1'b0;
                state_next  = S_READ_LAST;
              end
            end
            KIND_CHECK: begin
              cmd.res_sel = RES_TAG;
            end
            default: begin
            end
          endcase
        end else if (sts.scan_end) begin
          cmd.set_res = 1'b1;
          cmd.append  = (sts.kind == KIND_ADD);
          state_next  = S_FINISH;
        end
      end
      S_READ_LAST: begin
        cmd.read_last = 1'b1;
        state_next    = S_MOVE;
      end
      S_MOVE: begin
        cmd.move      = 1'b1;
        cmd.dec_count = 1'b1;
        cmd.set_res   = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/bmt_dp.sv @@
// Datapath of the breakpoint match table: request, count, scan and result registers.
`default_nettype none
module bmt_dp #(
  parameter int MAX_ENTRIES = 128,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire bmt_pkg::req_t          req_data,
  input  wire bmt_pkg::cmd_t          cmd,
  output bmt_pkg::sts_t               sts,
  output logic                        rsp_valid,
  input  wire logic                   rsp_ready,
  output bmt_pkg::rsp_t               rsp_data,
  output logic                        ram_wr_en,
  output logic [AW-1:0]               ram_wr_addr,
  output logic [bmt_pkg::ENTRY_W-1:0] ram_wr_data,
  output logic                        ram_rd_en,
  output logic [AW-1:0]               ram_rd_addr,
  input  wire logic [bmt_pkg::ENTRY_W-1:0] ram_rd_data
);
  import bmt_pkg::*;

  req_t          req;
  rsp_t          res;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] cmp_idx;
  logic [AW-1:0] match_idx;
  logic          cmp_valid;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] last_addr;
  logic          issue;
  logic          equal;
  entry_t        rd_entry;
  entry_t        new_entry;

  assign rd_entry  = entry_t'(ram_rd_data);
  assign count_m1  = count - CW'(1);
  assign last_addr = count_m1[AW-1:0];
  assign issue     = cmd.scan_en && (idx < count);
  assign equal     = (rd_entry.method_id == req.method_id) &&
                     (rd_entry.line_number == req.line_number);

  assign new_entry.method_id   = req.method_id;
  assign new_entry.line_number = req.line_number;
  assign new_entry.request_tag = req.request_tag;

  assign ram_rd_en   = issue || cmd.read_last;
  assign ram_rd_addr = cmd.read_last ? last_addr : idx[AW-1:0];
  assign ram_wr_en   = cmd.append || cmd.move;
  assign ram_wr_addr = cmd.move ? match_idx : count[AW-1:0];
  assign ram_wr_data = cmd.move ? ram_rd_data : ENTRY_W'(new_entry);

  always_comb begin
    sts.kind       = req.kind;
    sts.full       = (count == CW'(MAX_ENTRIES));
    sts.empty      = (count == '0);
    sts.step_mode  = (req.step_target_depth != '0);
    sts.step_hit   = (req.step_target_depth != '0) &&
                     (req.call_depth <= req.step_target_depth);
    sts.cmp_hit    = cmp_valid && equal;
    sts.scan_end   = cmp_valid && !equal && (cmp_idx == last_addr);
    sts.match_last = (cmp_idx == last_addr);
    sts.out_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.dec_count) begin
        count <= count_m1;
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= req_data;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CW'(1);
    end
    if (issue) begin
      cmp_idx <= idx[AW-1:0];
    end
    if (sts.cmp_hit) begin
      match_idx <= cmp_idx;
    end
    if (cmd.set_res) begin
      res.accepted     <= 1'b1;
      res.hit          <= 1'b0;
      res.hit_tag      <= TAG_NONE;
      res.step_cleared <= 1'b0;
      unique case (cmd.res_sel)
        RES_PLAIN: begin
        end
        RES_FULL: begin
          res.accepted <= 1'b0;
        end
        RES_STEP: begin
          res.hit          <= 1'b1;
          res.step_cleared <= 1'b1;
        end
        RES_TAG: begin
          res.hit     <= 1'b1;
          res.hit_tag <= {1'b0, rd_entry.request_tag};
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_out) begin
      rsp_data <= res;
    end
  end

endmodule
`default_nettype wire

@@ design/breakpoint_match_table.sv @@
// Top level of the breakpoint match table.
// Usage: a request enters on req_valid/req_ready with payload req_data and
// yields exactly one response on rsp_valid/rsp_ready with payload rsp_data.
// Requests are add, remove, clear all and check of (method, line) pairs.
// One request is worked on at a time; req_ready is high only while idle.
// Clear all, a full add, a step-mode check or any request on an
// empty table is settled in the decode state without a table scan.
// Add, remove and non-step check read the table one entry per cycle from
// a single RAM read port; a remove that matches an entry other than the
// last then reads the last entry and moves it into the freed slot.
// The next request is taken in the cycle after the response register loads.
// The response waits in an output register, so the next request is taken
// while it is stalled; a second finished response waits until it drains.
// Reset empties the table at once and drops any pending response; the
// entry storage itself is not cleared.
`default_nettype none
module breakpoint_match_table #(
  parameter int MAX_ENTRIES = 128
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire bmt_pkg::req_t req_data,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output bmt_pkg::rsp_t      rsp_data
);
  import bmt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cmd_t               cmd;
  sts_t               sts;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  bmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_data    (req_data),
    .cmd         (cmd),
    .sts         (sts),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_data    (rsp_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bmt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
`default_nettype wire

@@ design/bmt_checker.sv @@
// Port-level assertion checker of the breakpoint match table and its bind.
`default_nettype none
`include "breakpoint_match_table_assert.svh"
module bmt_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire bmt_pkg::rsp_t rsp_data
);
  import bmt_pkg::*;

  `BMT_ASSERT_RST(a_reset_clears, rst |=> !rsp_valid, "Response valid after reset.")
  `BMT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "Stalled response changed.")
  `BMT_ASSERT(a_step_tag, rsp_valid && rsp_data.step_cleared |-> rsp_data.hit && rsp_data.hit_tag == TAG_NONE, "Step stop without hit or with a tag.")
  `BMT_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "Request taken while busy.")
  `BMT_ASSERT(a_match_tag, rsp_valid && rsp_data.hit && !rsp_data.step_cleared |-> !rsp_data.hit_tag[31], "Breakpoint hit with a negative tag.")

endmodule

bind breakpoint_match_table bmt_checker u_bmt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
`default_nettype wire

@@ bench/bmt_checker.sv @@
// Checker that predicts and compares every response of the breakpoint match table.
module bmt_scoreboard
  import bmt_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  entry_t bp_slots [DEPTH];
  int     live_count;
  int     mismatches;
  rsp_t   awaited_rsp [$];

  function automatic rsp_t apply_request(input req_t r);
    rsp_t res;
    int   slot;
    res.accepted     = 1'b1;
    res.hit          = 1'b0;
    res.hit_tag      = TAG_NONE;
    res.step_cleared = 1'b0;
    slot = -1;
    for (int i = 0; i < live_count; i++) begin
      if (slot < 0 && bp_slots[i].method_id == r.method_id &&
          bp_slots[i].line_number == r.line_number) begin
        slot = i;
      end
    end
    case (r.kind)
      KIND_ADD: begin
        if (live_count >= DEPTH) begin
          res.accepted = 1'b0;
        end else if (slot < 0) begin
          bp_slots[live_count].method_id   = r.method_id;
          bp_slots[live_count].line_number = r.line_number;
          bp_slots[live_count].request_tag = r.request_tag;
          live_count++;
        end
      end
      KIND_REMOVE: begin
        if (slot >= 0) begin
          if (slot < live_count - 1) begin
            bp_slots[slot] = bp_slots[live_count - 1];
          end
          live_count--;
        end
      end
      KIND_CLEAR: begin
        live_count = 0;
      end
      default: begin
        if (r.step_target_depth != '0) begin
          if (r.call_depth <= r.step_target_depth) begin
            res.hit          = 1'b1;
            res.step_cleared = 1'b1;
          end
        end else if (slot >= 0) begin
          res.hit     = 1'b1;
          res.hit_tag = {1'b0, bp_slots[slot].request_tag};
        end
      end
    endcase
    return res;
  endfunction

  task automatic compare_field(input string field, input logic signed [32:0] want_v,
                               input logic signed [32:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      live_count = 0;
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: response with no request outstanding, expected none, got %p",
                   $time, rsp_data);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("accepted", want.accepted, rsp_data.accepted);
          compare_field("hit", want.hit, rsp_data.hit);
          compare_field("hit_tag", want.hit_tag, rsp_data.hit_tag);
          compare_field("step_cleared", want.step_cleared, rsp_data.step_cleared);
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp.push_back(apply_request(req_data));
      end
    end
    fail_count <= mismatches;
    pending    <= awaited_rsp.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the breakpoint match table testbench: clock, reset, stimulus and verdict.
module tb_top;
  import bmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 128;
  localparam int TOTAL_ITEMS = 1950;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp_data;
  int   fail_count;
  int   pending;

  int          send_idle;
  int          recv_idle;
  int          hold_gen;
  int          sent;
  logic [63:0] method_pool [8];

  breakpoint_match_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  bmt_scoreboard #(
    .DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver holds off for a long stretch whenever the stimulus bumps hold_gen.
  initial begin
    int held;
    int seen_hold;
    rsp_ready = 1'b0;
    seen_hold = 0;
    forever begin
      @(negedge clk);
      if (hold_gen != seen_hold) begin
        seen_hold = hold_gen;
        rsp_ready <= 1'b0;
        for (held = 0; held < 80; held++) begin
          @(negedge clk);
        end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic req_t build(input logic [1:0] kind, input logic [63:0] method_id,
                                 input logic [30:0] line_number,
                                 input logic [30:0] request_tag,
                                 input logic [15:0] call_depth,
                                 input logic [15:0] step_target_depth);
    req_t r;
    r.kind              = kind;
    r.method_id         = method_id;
    r.line_number       = line_number;
    r.request_tag       = request_tag;
    r.call_depth        = call_depth;
    r.step_target_depth = step_target_depth;
    return r;
  endfunction

  function automatic req_t random_request(input logic [1:0] kind);
    req_t r;
    r.kind = kind;
    if ($urandom_range(0, 9) == 0) begin
      r.method_id = {$urandom(), $urandom()};
    end else begin
      r.method_id = method_pool[$urandom_range(0, 7)];
    end
    case ($urandom_range(0, 9))
      0:       r.line_number = 31'($urandom());
      1:       r.line_number = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
      default: r.line_number = 31'($urandom_range(0, 15));
    endcase
    r.request_tag = 31'($urandom());
    r.call_depth  = 16'($urandom());
    case ($urandom_range(0, 5))
      0, 1, 2: r.step_target_depth = '0;
      3:       r.step_target_depth = 16'($urandom());
      default: r.step_target_depth = r.call_depth + 16'($urandom_range(0, 2)) - 16'd1;
    endcase
    return r;
  endfunction

  task automatic send(input req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    req_t r;
    int   pick;
    int   burst;
    int   w;
    bit   mid_hold;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    send_idle = 25;
    recv_idle = 67;
    hold_gen  = 0;
    sent      = 0;
    mid_hold  = 1'b0;
    method_pool[0] = '0;
    method_pool[1] = '1;
    for (int k = 2; k < 8; k++) begin
      method_pool[k] = {$urandom(), $urandom()};
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(build(KIND_CHECK, '0, '0, '0, '0, '0));
    send(build(KIND_REMOVE, '0, '0, '0, '0, '0));
    send(build(KIND_ADD, '1, '1, '1, '1, '0));
    send(build(KIND_ADD, '1, '1, 31'h1234, '0, '0));
    send(build(KIND_CHECK, '1, '1, '0, '0, '0));
    send(build(KIND_ADD, '0, '0, '0, '0, '0));
    send(build(KIND_CHECK, '0, '0, '1, '1, '0));
    send(build(KIND_ADD, 64'h5A5A_A5A5_0F0F_F0F0, 31'd5, 31'h2AAA_AAAA, '0, '0));
    send(build(KIND_CHECK, '1, '1, '0, 16'hFFFF, 16'hFFFF));
    send(build(KIND_CHECK, '1, '1, '0, 16'hFFFF, 16'hFFFE));
    send(build(KIND_CHECK, '0, '0, '0, 16'd0, 16'd1));
    send(build(KIND_CHECK, '0, '0, '0, 16'd2, 16'd1));
    send(build(KIND_REMOVE, '1, '1, '0, '0, '0));
    send(build(KIND_CHECK, 64'h5A5A_A5A5_0F0F_F0F0, 31'd5, '0, '0, '0));
    send(build(KIND_CHECK, '1, '1, '0, '0, '0));
    send(build(KIND_REMOVE, 64'h5A5A_A5A5_0F0F_F0F0, 31'd6, '0, '0, '0));
    send(build(KIND_REMOVE, 64'h5A5A_A5A5_0F0F_F0F0, 31'd5, '0, '0, '0));
    send(build(KIND_CHECK, '0, '0, '0, '0, '0));
    send(build(KIND_CLEAR, '1, '1, '1, '1, '1));
    send(build(KIND_CHECK, '0, '0, '0, '0, '0));
    send(build(KIND_CLEAR, '0, '0, '0, '0, '0));
    send(build(KIND_ADD, 64'd1, 31'd1, 31'd9, '0, '0));
    send(build(KIND_CHECK, 64'h8000_0000_0000_0001, 31'd1, '0, '0, '0));
    send(build(KIND_CHECK, 64'd1, 31'd1, '0, '0, '0));

    while (sent < TOTAL_ITEMS) begin
      if (sent >= 1300 && send_idle != 0) begin
        send_idle = 0;
        recv_idle = 0;
        hold_gen++;
      end else if (sent >= 650 && sent < 1300 && send_idle == 25) begin
        send_idle = 67;
        recv_idle = 25;
      end
      if (!mid_hold && sent >= 300) begin
        mid_hold = 1'b1;
        hold_gen++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send(random_request(KIND_CLEAR));
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          r = random_request(KIND_ADD);
          r.method_id   = method_pool[k % 8];
          r.line_number = 31'(k / 8);
          send(r);
        end
        r = random_request(KIND_ADD);
        r.method_id   = method_pool[3];
        r.line_number = 31'd7;
        send(r);
        send(random_request(KIND_ADD));
        for (int k = 0; k < 6; k++) begin
          send(random_request(($urandom_range(0, 1) == 0) ? KIND_REMOVE : KIND_CHECK));
        end
      end else if (pick < 25) begin
        r = random_request(KIND_ADD);
        send(r);
        r.kind              = KIND_CHECK;
        r.step_target_depth = '0;
        send(r);
        r.kind = KIND_REMOVE;
        send(r);
        r.kind = KIND_CHECK;
        send(r);
      end else begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst; k++) begin
          w = $urandom_range(0, 99);
          if (w < 40) begin
            send(random_request(KIND_ADD));
          end else if (w < 60) begin
            send(random_request(KIND_REMOVE));
          end else if (w < 95) begin
            send(random_request(KIND_CHECK));
          end else begin
            send(random_request(KIND_CLEAR));
          end
        end
      end
    end

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bmt_pkg.sv
design/bmt_ram.sv
design/bmt_ctrl.sv
design/bmt_dp.sv
design/breakpoint_match_table.sv
design/bmt_checker.sv
bench/bmt_checker.sv
bench/tb_top.sv
